// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/irls_pkg.sv =====
// Types, constants and helper functions of the IR line sensor block.
package irls_pkg;

    localparam int CHANNELS    = 6;
    localparam int CH_W        = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_NW      = 28;
    localparam int DIV_DW      = 17;

    localparam logic [12:0]     Q12_ONE        = 13'd4096;
    localparam logic [12:0]     CAL_HIGH_RESET = 13'd2007;
    localparam logic [CH_W-1:0] CH_LAST        = CH_W'(CHANNELS - 1);

    typedef enum logic [1:0] {
        KIND_SCAN  = 2'd0,
        KIND_WIDEN = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic [CHANNELS-1:0][11:0]  samples;
    } cmd_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIV_NW:0]   num;
        logic signed [DIV_DW:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [DIV_NW:0]   quo;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG,
        S_MAC,
        S_WSUM,
        S_CAL_GO,
        S_CAL_WAIT,
        S_PAD,
        S_POS_GO,
        S_POS_WAIT,
        S_EMIT
    } back_state_t;

    // Clamp a signed quotient to [0, 1.0] in Q12.
    function automatic logic [12:0] clamp_q12(input logic signed [DIV_NW:0] v);
        logic [12:0] r;
        if (v < 0)
        begin
            r = 13'd0;
        end
        else if (v > $signed({16'd0, Q12_ONE}))
        begin
            r = Q12_ONE;
        end
        else
        begin
            r = v[12:0];
        end
        return r;
    endfunction

endpackage

// ===== src/irls_ifs.sv =====
// Valid/ready channel interfaces for scan items and result items.
interface irls_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] sample_ch0;
    logic [11:0] sample_ch1;
    logic [11:0] sample_ch2;
    logic [11:0] sample_ch3;
    logic [11:0] sample_ch4;
    logic [11:0] sample_ch5;

    modport source (output valid, kind, sample_ch0, sample_ch1, sample_ch2,
                    sample_ch3, sample_ch4, sample_ch5, input ready);
    modport sink (input valid, kind, sample_ch0, sample_ch1, sample_ch2,
                  sample_ch3, sample_ch4, sample_ch5, output ready);
endinterface

interface irls_out_if;
    logic               valid;
    logic               ready;
    logic               emitter_phase;
    logic               frame_done;
    logic signed [18:0] weighted_sum;
    logic signed [14:0] line_position;
    logic               position_valid;
    logic [2:0]         peak_slot;

    modport source (output valid, emitter_phase, frame_done, weighted_sum,
                    line_position, position_valid, peak_slot, input ready);
    modport sink (input valid, emitter_phase, frame_done, weighted_sum,
                  line_position, position_valid, peak_slot, output ready);
endinterface

// ===== src/irls_front.sv =====
// Front end: accept input beats and classify them into queue commands.
module irls_front (
    irls_in_if.sink          in_ch,
    input  logic             q_full,
    output logic             q_push,
    output irls_pkg::cmd_t   q_data
);

    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;

    always_comb
    begin
        q_data.kind       = irls_pkg::kind_t'(in_ch.kind);
        q_data.samples[0] = in_ch.sample_ch0;
        q_data.samples[1] = in_ch.sample_ch1;
        q_data.samples[2] = in_ch.sample_ch2;
        q_data.samples[3] = in_ch.sample_ch3;
        q_data.samples[4] = in_ch.sample_ch4;
        q_data.samples[5] = in_ch.sample_ch5;
    end

endmodule

// ===== src/irls_fifo.sv =====
// Two-entry command queue between front and back.
module irls_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  irls_pkg::cmd_t   push_data,
    input  logic             pop,
    output irls_pkg::cmd_t   head,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = $clog2(irls_pkg::QUEUE_DEPTH);

    irls_pkg::cmd_t   mem_reg [irls_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PTR_W + 1)'(irls_pkg::QUEUE_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/irls_div.sv =====
// Shared signed divider, restoring, one quotient bit per cycle, truncating.
module irls_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  irls_pkg::div_req_t   req,
    output irls_pkg::div_rsp_t   rsp
);

    localparam int NW = irls_pkg::DIV_NW;
    localparam int DW = irls_pkg::DIV_DW;
    localparam int CNT_W = $clog2(NW + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [NW-1:0]       q_reg;
    logic [DW-1:0]       rem_reg;
    logic [DW-1:0]       den_reg;
    logic                neg_reg;
    logic signed [NW:0]  quo_reg;

    logic signed [NW:0]  num_abs;
    logic signed [DW:0]  den_abs;
    logic [DW:0]         shifted;
    logic [DW:0]         diff;
    logic                qbit;
    logic [DW-1:0]       rem_new;
    logic [NW-1:0]       q_new;

    always_comb
    begin
        num_abs = req.num[NW] ? -req.num : req.num;
        den_abs = req.den[DW] ? -req.den : req.den;
        shifted = {rem_reg, q_reg[NW-1]};
        diff    = shifted - {1'b0, den_reg};
        qbit    = (shifted >= {1'b0, den_reg});
        rem_new = qbit ? diff[DW-1:0] : shifted[DW-1:0];
        q_new   = {q_reg[NW-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= num_abs[NW-1:0];
            rem_reg <= '0;
            den_reg <= den_abs[DW-1:0];
            neg_reg <= req.num[NW] ^ req.den[DW];
        end
        else if (busy_reg)
        begin
            q_reg   <= q_new;
            rem_reg <= rem_new;
            if (cnt_reg == CNT_W'(1))
            begin
                quo_reg <= neg_reg ? -$signed({1'b0, q_new}) : $signed({1'b0, q_new});
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== src/irls_back.sv =====
// Back end: scan accumulation, calibration, frame sequencer and result register.
module irls_back #(
    parameter int OVERSAMPLE = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  irls_pkg::cmd_t       q_head,
    output logic                 q_pop,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output irls_pkg::div_req_t   div_req,
    input  irls_pkg::div_rsp_t   div_rsp,
    irls_out_if.source           out_ch
);

    localparam int NW     = irls_pkg::DIV_NW;
    localparam int DW     = irls_pkg::DIV_DW;
    localparam int CHN    = irls_pkg::CHANNELS;
    localparam int SLOT_W = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
    localparam int ACC_W  = 14 + SLOT_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(OVERSAMPLE - 1);
    // Reciprocal of OVERSAMPLE, exact for every accumulated magnitude
    localparam int RECIP_SH = 20;
    localparam logic [RECIP_SH:0] AVG_RECIP =
        (RECIP_SH + 1)'((2 ** RECIP_SH + OVERSAMPLE - 1) / OVERSAMPLE);

    irls_pkg::back_state_t state_reg;
    irls_pkg::back_state_t state_next;

    logic                     phase_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic signed [ACC_W-1:0]  acc_reg    [CHN];
    logic [12:0]              proc_reg   [CHN];
    logic [12:0]              low_reg    [CHN];
    logic [12:0]              high_reg   [CHN];
    logic signed [15:0]       weight_reg [CHN];
    logic [12:0]              cal_reg    [CHN];
    logic signed [31:0]       wacc_reg;
    logic [12:0]              max_reg;
    logic [2:0]               peak_reg;
    logic [irls_pkg::CH_W-1:0] ch_reg;
    logic [15:0]              sum_reg;
    logic signed [17:0]       num_reg;
    logic                     done_reg;
    logic signed [18:0]       last_ws_reg;
    logic signed [14:0]       last_pos_reg;
    logic                     last_valid_reg;
    logic [2:0]               last_peak_reg;
    logic                     out_valid_reg;
    logic                     out_phase_reg;
    logic                     out_done_reg;
    logic signed [18:0]       out_ws_reg;
    logic signed [14:0]       out_pos_reg;
    logic                     out_pvalid_reg;
    logic [2:0]               out_peak_reg;

    logic                     frame_end;
    logic                     emit_fire;
    logic signed [13:0]       cal_n;
    logic signed [13:0]       cal_s;
    logic                     span_zero;
    logic                     cal_write;
    logic [12:0]              cal_c;
    logic signed [29:0]       prod;
    logic signed [31:0]       wround;
    logic [12:0]              e0;
    logic [12:0]              e7;
    logic [15:0]              sum_calc;
    logic signed [17:0]       num_calc;
    logic [ACC_W-1:0]         avg_abs;
    logic [ACC_W+RECIP_SH:0]  avg_prod;
    logic [ACC_W-1:0]         avg_mag;
    logic                     avg_neg;
    logic signed [NW:0]       avg_q;

    assign frame_end = (q_head.kind == irls_pkg::KIND_SCAN) && phase_reg &&
                       (slot_reg == LAST_SLOT);
    assign emit_fire = (state_reg == irls_pkg::S_EMIT) && (!out_valid_reg || out_ch.ready);

    // Datapath helpers for the selected channel
    always_comb
    begin
        cal_n     = $signed({1'b0, proc_reg[ch_reg]}) - $signed({1'b0, low_reg[ch_reg]});
        cal_s     = $signed({1'b0, high_reg[ch_reg]}) - $signed({1'b0, low_reg[ch_reg]});
        span_zero = (cal_s == '0);
        cal_write = ((state_reg == irls_pkg::S_CAL_GO) && span_zero) ||
                    ((state_reg == irls_pkg::S_CAL_WAIT) && div_rsp.done);
        if (state_reg == irls_pkg::S_CAL_GO)
        begin
            cal_c = (cal_n > 0) ? irls_pkg::Q12_ONE : 13'd0;
        end
        else
        begin
            cal_c = irls_pkg::clamp_q12(div_rsp.quo);
        end
        // Truncating average: divide the magnitude, then apply the sign, inverted on odd channels
        avg_abs  = acc_reg[ch_reg][ACC_W-1] ? ACC_W'(-acc_reg[ch_reg])
                                            : ACC_W'(acc_reg[ch_reg]);
        avg_prod = {{(RECIP_SH + 1){1'b0}}, avg_abs} * {{ACC_W{1'b0}}, AVG_RECIP};
        avg_mag  = avg_prod[ACC_W+RECIP_SH-1:RECIP_SH];
        avg_neg  = acc_reg[ch_reg][ACC_W-1] ^ ch_reg[0];
        avg_q    = avg_neg ? -$signed((NW + 1)'(avg_mag)) : $signed((NW + 1)'(avg_mag));
        prod   = $signed({1'b0, proc_reg[ch_reg]}) * weight_reg[ch_reg];
        wround = wacc_reg + 32'sd2048;

        e0 = (peak_reg == 3'd1) ? (irls_pkg::Q12_ONE - cal_reg[0]) : 13'd0;
        e7 = (peak_reg == 3'd6) ? (irls_pkg::Q12_ONE - cal_reg[5]) : 13'd0;
        sum_calc = 16'(e0) + 16'(e7);
        for (int i = 0; i < CHN; i++)
        begin
            sum_calc = sum_calc + 16'(cal_reg[i]);
        end
        num_calc = 18'sd4 * ($signed({5'd0, e7}) - $signed({5'd0, e0}))
                 + 18'sd3 * ($signed({5'd0, cal_reg[5]}) - $signed({5'd0, cal_reg[0]}))
                 + 18'sd2 * ($signed({5'd0, cal_reg[4]}) - $signed({5'd0, cal_reg[1]}))
                 + ($signed({5'd0, cal_reg[3]}) - $signed({5'd0, cal_reg[2]}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= irls_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_req    = '0;
        case (state_reg)
            irls_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = frame_end ? irls_pkg::S_AVG : irls_pkg::S_EMIT;
                end
            end
            irls_pkg::S_AVG:
            begin
                state_next = irls_pkg::S_MAC;
            end
            irls_pkg::S_MAC:
            begin
                state_next = (ch_reg == irls_pkg::CH_LAST) ? irls_pkg::S_WSUM
                                                           : irls_pkg::S_AVG;
            end
            irls_pkg::S_WSUM:
            begin
                state_next = irls_pkg::S_CAL_GO;
            end
            irls_pkg::S_CAL_GO:
            begin
                if (span_zero)
                begin
                    if (ch_reg == irls_pkg::CH_LAST)
                    begin
                        state_next = irls_pkg::S_PAD;
                    end
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = (NW + 1)'($signed({cal_n, 12'd0}));
                    div_req.den   = (DW + 1)'(cal_s);
                    state_next    = irls_pkg::S_CAL_WAIT;
                end
            end
            irls_pkg::S_CAL_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (ch_reg == irls_pkg::CH_LAST) ? irls_pkg::S_PAD
                                                               : irls_pkg::S_CAL_GO;
                end
            end
            irls_pkg::S_PAD:
            begin
                state_next = irls_pkg::S_POS_GO;
            end
            irls_pkg::S_POS_GO:
            begin
                if (sum_reg == '0)
                begin
                    state_next = irls_pkg::S_EMIT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {num_reg[16:0], 12'd0};
                    div_req.den   = {1'b0, sum_reg, 1'b0};
                    state_next    = irls_pkg::S_POS_WAIT;
                end
            end
            irls_pkg::S_POS_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = irls_pkg::S_EMIT;
                end
            end
            irls_pkg::S_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = irls_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = irls_pkg::S_IDLE;
            end
        endcase
    end

    // Architectural state with reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 1'b0;
            slot_reg       <= '0;
            done_reg       <= 1'b0;
            last_ws_reg    <= '0;
            last_pos_reg   <= '0;
            last_valid_reg <= 1'b0;
            last_peak_reg  <= '0;
            out_valid_reg  <= 1'b0;
            ch_reg         <= '0;
            for (int i = 0; i < CHN; i++)
            begin
                acc_reg[i]    <= '0;
                proc_reg[i]   <= '0;
                low_reg[i]    <= '0;
                high_reg[i]   <= irls_pkg::CAL_HIGH_RESET;
                weight_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we && (cfg_index <= irls_pkg::CH_LAST))
            begin
                weight_reg[cfg_index] <= cfg_data;
            end

            if (state_reg == irls_pkg::S_IDLE && !q_empty)
            begin
                done_reg <= frame_end;
                ch_reg   <= '0;
                case (q_head.kind)
                    irls_pkg::KIND_SCAN:
                    begin
                        for (int i = 0; i < CHN; i++)
                        begin
                            if (!phase_reg)
                            begin
                                acc_reg[i] <= (slot_reg == '0)
                                    ? $signed({{(ACC_W - 12){1'b0}}, q_head.samples[i]})
                                    : acc_reg[i] + $signed({{(ACC_W - 12){1'b0}},
                                                            q_head.samples[i]});
                            end
                            else
                            begin
                                acc_reg[i] <= acc_reg[i] - $signed({{(ACC_W - 12){1'b0}},
                                                                    q_head.samples[i]});
                            end
                        end
                        phase_reg <= !phase_reg;
                        if (phase_reg)
                        begin
                            slot_reg <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                        end
                    end
                    irls_pkg::KIND_WIDEN:
                    begin
                        for (int i = 0; i < CHN; i++)
                        begin
                            if (proc_reg[i] < low_reg[i])
                            begin
                                low_reg[i] <= proc_reg[i];
                            end
                            else if (proc_reg[i] > high_reg[i])
                            begin
                                high_reg[i] <= proc_reg[i];
                            end
                        end
                    end
                    irls_pkg::KIND_CLEAR:
                    begin
                        for (int i = 0; i < CHN; i++)
                        begin
                            low_reg[i]  <= irls_pkg::Q12_ONE;
                            high_reg[i] <= '0;
                        end
                    end
                    default:
                    begin
                        done_reg <= 1'b0;
                    end
                endcase
            end

            if (state_reg == irls_pkg::S_AVG)
            begin
                proc_reg[ch_reg] <= irls_pkg::clamp_q12(avg_q);
            end
            if (state_reg == irls_pkg::S_MAC)
            begin
                ch_reg <= ch_reg + 1'b1;
            end
            if (state_reg == irls_pkg::S_WSUM)
            begin
                last_ws_reg <= wround[30:12];
                ch_reg      <= '0;
            end
            if (cal_write)
            begin
                ch_reg <= ch_reg + 1'b1;
            end
            if (state_reg == irls_pkg::S_POS_GO && sum_reg == '0)
            begin
                last_pos_reg   <= '0;
                last_valid_reg <= 1'b0;
                last_peak_reg  <= peak_reg;
            end
            if (state_reg == irls_pkg::S_POS_WAIT && div_rsp.done)
            begin
                last_pos_reg   <= div_rsp.quo[14:0];
                last_valid_reg <= 1'b1;
                last_peak_reg  <= peak_reg;
            end

            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Frame scratch and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == irls_pkg::S_IDLE)
        begin
            wacc_reg <= '0;
        end
        if (state_reg == irls_pkg::S_MAC)
        begin
            wacc_reg <= wacc_reg + 32'(prod);
        end
        if (state_reg == irls_pkg::S_WSUM)
        begin
            max_reg  <= '0;
            peak_reg <= '0;
        end
        if (cal_write)
        begin
            cal_reg[ch_reg] <= cal_c;
            if (cal_c > max_reg)
            begin
                max_reg  <= cal_c;
                peak_reg <= 3'(ch_reg) + 3'd1;
            end
        end
        if (state_reg == irls_pkg::S_PAD)
        begin
            sum_reg <= sum_calc;
            num_reg <= num_calc;
        end
        if (emit_fire)
        begin
            out_phase_reg  <= phase_reg;
            out_done_reg   <= done_reg;
            out_ws_reg     <= last_ws_reg;
            out_pos_reg    <= last_pos_reg;
            out_pvalid_reg <= last_valid_reg;
            out_peak_reg   <= last_peak_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.emitter_phase  = out_phase_reg;
    assign out_ch.frame_done     = out_done_reg;
    assign out_ch.weighted_sum   = out_ws_reg;
    assign out_ch.line_position  = out_pos_reg;
    assign out_ch.position_valid = out_pvalid_reg;
    assign out_ch.peak_slot      = out_peak_reg;

endmodule

// ===== src/ir_line_sensor_position.sv =====
// IR line sensor position block, top level.
// Usage: in_ch carries one beat per item: kind (scan, widen bounds, clear
// bounds) and six 12-bit ADC readings. Scans alternate emitter pattern A and
// pattern B; out_ch returns exactly one beat per item with the phase to
// light next, a frame-done flag and the last frame's weighted sum, line
// position, valid flag and peak slot. Weights are written on cfg_we /
// cfg_index / cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. An item that does not
// close a frame goes from the queue through the emit state into the
// output register. The B scan that closes a frame first averages and
// weights each channel in turn, then runs seven divisions (six
// calibrations, one position) one after another through the single
// 28-step divider; a zero span or a zero sum skips its division.
// The back end takes the next item from the queue only after it has emitted
// the last; the frame item sets the pace when frames are short.
// A two-entry queue lets in_ch take beats while the back end is busy; the
// output register lets the back end finish an item while out_ch stalls.
// When out_ch stalls, the queue fills and in_ch.ready drops.
// Reset (rst_n low, asynchronous) returns to pattern A, clears weights,
// stores and results, and sets the calibration bounds to low 0, high 0.49.
`include "assert_macros.svh"

module ir_line_sensor_position #(
    parameter int OVERSAMPLE = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    irls_in_if.sink     in_ch,
    irls_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Queue between front and back
    logic                 q_push;
    logic                 q_pop;
    logic                 q_empty;
    logic                 q_full;
    irls_pkg::cmd_t       q_in;
    irls_pkg::cmd_t       q_head;

    // Shared divider handshake
    irls_pkg::div_req_t   div_req;
    irls_pkg::div_rsp_t   div_rsp;

    irls_front u_front (
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    irls_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    irls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Back end runs the frame sequence and holds the output register
    irls_back #(
        .OVERSAMPLE (OVERSAMPLE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_ch    (out_ch)
    );

    // Never push into a full queue
    `ASSERT_IMPLIES(a_push_room, q_push, !q_full)
    // A frame closes on a B scan, so pattern A is lit next
    `ASSERT_IMPLIES(a_frame_phase, out_ch.valid && out_ch.frame_done, !out_ch.emitter_phase)
    // Start the divider only while it is idle
    `ASSERT_IMPLIES(a_div_idle, div_req.start, !div_rsp.busy)
    // A started division keeps the divider busy in the next cycle
    `ASSERT_NEXT(a_div_busy, div_req.start, div_rsp.busy)

endmodule
